// ===== hdl/sha_pkg.sv =====
package sha_pkg;

	localparam int unsigned CountW = 61;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_DONE,
		ST_OUT
	} bst_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		round_k = k[t];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		init_h = h[i];
	endfunction

endpackage

// ===== hdl/sha_front.sv =====
module sha_front
	import sha_pkg::*;
#(
	parameter int unsigned Depth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] message_byte,
	input  logic       byte_present,
	input  logic       end_of_message,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_take
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign full      = (cnt_q == (AW+1)'(Depth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];
	// idle items are dropped here
	assign wr = push && !full && (byte_present || end_of_message);
	assign rd = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= '{data: message_byte, has_byte: byte_present, eom: end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (rd) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// ===== hdl/sha_core.sv =====
module sha_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_take,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	bst_t              st_q, st_d;
	logic [31:0]       h_q [8];
	logic [31:0]       v_q [8];
	logic [31:0]       w_q [16];
	logic [CountW-1:0] cnt_q;
	logic [5:0]        pos_q;
	logic [5:0]        rnd_q;
	logic              final_q;
	logic              mark_q;
	logic              len_q;
	logic [2:0]        oidx_q;

	logic        byte_wr;
	logic [7:0]  byte_val;
	logic [5:0]  byte_pos;
	logic        start_comp;
	logic        len_start;
	logic [31:0] s0, s1, w_new, t1, t2;
	logic [63:0] bits;

	assign bits = {cnt_q, 3'b000};
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = s1 + w_q[9] + s0 + w_q[0];
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_q[0];
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.has_byte && pos_q == 6'd63) st_d = ST_COMP;
					else if (cmd.eom)                   st_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (pos_q == 6'd63 || pos_q == LenPos - 6'd1) st_d = ST_COMP;
			end
			ST_COMP: if (rnd_q == 6'd63) st_d = ST_DONE;
			ST_DONE: begin
				if (len_q)        st_d = ST_OUT;
				else if (final_q) st_d = ST_PAD;
				else              st_d = ST_IDLE;
			end
			ST_OUT: if (pop && oidx_q == 3'd7) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take   = 1'b0;
		byte_wr    = 1'b0;
		byte_val   = cmd.data;
		byte_pos   = pos_q;
		start_comp = 1'b0;
		len_start  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				cmd_take   = cmd_valid;
				byte_wr    = cmd_valid && cmd.has_byte;
				start_comp = cmd_valid && cmd.has_byte && pos_q == 6'd63;
			end
			ST_PAD: begin
				// marker byte first, then zeros; length goes in after byte 55
				byte_wr    = 1'b1;
				byte_val   = mark_q ? PadByte : 8'h00;
				len_start  = (pos_q == LenPos - 6'd1);
				start_comp = (pos_q == 6'd63) || (pos_q == LenPos - 6'd1);
			end
			default: ;
		endcase
	end

	assign empty       = (st_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			final_q <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			st_q <= st_d;
			if (byte_wr) pos_q <= pos_q + 6'd1;
			if (st_q == ST_IDLE && cmd_valid && cmd.has_byte) cnt_q <= cnt_q + 1'b1;
			if (st_q == ST_IDLE && cmd_valid && cmd.eom) begin
				final_q <= 1'b1;
				mark_q  <= 1'b1;
			end
			if (st_q == ST_PAD) mark_q <= 1'b0;
			if (start_comp && len_start) len_q <= 1'b1;
			if (st_q == ST_COMP) rnd_q <= rnd_q + 6'd1;
			if (st_q == ST_DONE) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (st_q == ST_OUT && pop) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
					cnt_q   <= '0;
					final_q <= 1'b0;
					len_q   <= 1'b0;
					pos_q   <= '0;
				end
			end
		end
	end

	// block word shift register: shifts during rounds to form the schedule
	always_ff @(posedge clk) begin
		if (st_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			if (byte_wr) begin
				w_q[byte_pos[5:2]][{~byte_pos[1:0], 3'b000} +: 8] <= byte_val;
			end
			if (start_comp) begin
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				if (len_start) begin
					w_q[14] <= bits[63:32];
					w_q[15] <= bits[31:0];
				end
			end
		end
	end
endmodule

// ===== hdl/sha256_message_hasher_unit.sv =====
// SHA-256 over a byte stream. Push one item per transaction: a byte, a bare end
// marker, or both; after end of message the eight digest words pop in order,
// word_index 0 first. A front queue takes items while the core works. The core
// takes bytes only while idle; each 64-byte block then runs 64 rounds and a
// feed-forward step, during which no bytes are taken. Padding writes the marker
// and zero bytes at one per cycle, possibly adding a second block.
module sha256_message_hasher_unit
	import sha_pkg::*;
#(
	parameter int unsigned QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	sha_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .push, .full, .message_byte, .byte_present, .end_of_message,
		.cmd_valid, .cmd, .cmd_take
	);

	sha_core u_core (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop,
		.digest_word, .word_index, .last_word
	);
endmodule
